[rtl/aabbfc_pkg.sv]
`default_nettype none

package aabbfc_pkg;

    localparam int FIELD_W         = 16;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int ROW_W           = 64;
    localparam int MARGIN_W        = 16;
    localparam int COORD_FRAC      = 8;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_LANES       = 4;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_ZERO  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MARGIN    = 3'd4;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

`default_nettype wire

[rtl/aabb_frustum_cull_unit.sv]
// Frustum culling of axis-aligned boxes against six clip planes.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the four view-projection rows and the reject margin; cfg_ready is always high.
// Configuration should only be written when no transaction is in flight.
// The plane coefficients derived from the row registers are held in their own
// registers, set before any box accepted afterwards reaches the multipliers.
// An input transaction carries the six box corner coordinates; it is accepted
// on a rising edge with in_valid high and in_stall low.
// Each box produces one output transaction carrying box_visible.
// The result passes four register stages: coordinate sums, the 36 plane
// multiplications, a pairwise add and the final add with sign test. out_valid
// rises when the box reaches the last stage, and the output transaction is
// taken at an edge where out_valid is high and out_stall is low.
// One box per cycle while out_stall is low, as every stage holds its own box.
// When out_stall is high the pipeline closes its gaps and then holds;
// in_stall rises only once every stage is occupied, so nothing is lost.
// Reset clears all valid flags and the configuration registers, which makes
// every plane zero and every box visible until the rows are written.
`default_nettype none

module aabb_frustum_cull_unit #(
    parameter int COORD_WIDTH = aabbfc_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = aabbfc_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [aabbfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [aabbfc_pkg::ROW_W-1:0]       cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [aabbfc_pkg::FIELD_W-1:0] box_min_x,
    input  wire logic signed [aabbfc_pkg::FIELD_W-1:0] box_min_y,
    input  wire logic signed [aabbfc_pkg::FIELD_W-1:0] box_min_z,
    input  wire logic signed [aabbfc_pkg::FIELD_W-1:0] box_max_x,
    input  wire logic signed [aabbfc_pkg::FIELD_W-1:0] box_max_y,
    input  wire logic signed [aabbfc_pkg::FIELD_W-1:0] box_max_z,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    box_visible
);
    import aabbfc_pkg::*;

    localparam int CV_W = (COORD_WIDTH > FIELD_W) ? FIELD_W + 1 : COORD_WIDTH;
    localparam int DV_W = CV_W + 1;

    stage_en_t                    stage_en;
    logic signed [COEF_WIDTH:0]   plane_coef [NUM_PLANES][NUM_LANES];
    logic [MARGIN_W-1:0]          margin;
    logic [FIELD_W-1:0]           lo_field [3];
    logic [FIELD_W-1:0]           hi_field [3];
    logic signed [DV_W-1:0]       sum [3];
    logic signed [DV_W-1:0]       dif [3];
    logic [NUM_PLANES-1:0]        reject;

    aabbfc_cfg_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .plane_coef (plane_coef),
        .margin     (margin)
    );

    aabbfc_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stage_en  (stage_en)
    );

    assign lo_field[0] = box_min_x;
    assign lo_field[1] = box_min_y;
    assign lo_field[2] = box_min_z;
    assign hi_field[0] = box_max_x;
    assign hi_field[1] = box_max_y;
    assign hi_field[2] = box_max_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        aabbfc_coord_prep #(
            .COORD_WIDTH (COORD_WIDTH),
            .DV_W        (DV_W)
        ) u_coord_prep (
            .clk  (clk),
            .load (stage_en.s1),
            .lo   (lo_field[a]),
            .hi   (hi_field[a]),
            .sum  (sum[a]),
            .dif  (dif[a])
        );
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        aabbfc_plane_eval #(
            .COEF_WIDTH (COEF_WIDTH),
            .DV_W       (DV_W)
        ) u_plane_eval (
            .clk      (clk),
            .stage_en (stage_en),
            .coef     (plane_coef[p]),
            .sum      (sum),
            .dif      (dif),
            .margin   (margin),
            .reject   (reject[p])
        );
    end

    assign box_visible = ~|reject;

endmodule

`default_nettype wire

[rtl/aabbfc_cfg_regs.sv]
`default_nettype none

module aabbfc_cfg_regs #(
    parameter int COEF_WIDTH = aabbfc_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [aabbfc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [aabbfc_pkg::ROW_W-1:0]            cfg_data,
    output logic signed [COEF_WIDTH:0]
        plane_coef [aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_LANES],
    output logic [aabbfc_pkg::MARGIN_W-1:0]              margin
);
    import aabbfc_pkg::*;

    localparam int LANES_W = NUM_LANES * COEF_WIDTH;
    localparam int PC_W    = COEF_WIDTH + 1;

    logic [ROW_W-1:0]    row_reg [NUM_LANES];
    logic [MARGIN_W-1:0] margin_reg;
    logic [LANES_W-1:0]  row_ext [NUM_LANES];
    logic signed [COEF_WIDTH-1:0] r [NUM_LANES][NUM_LANES];
    logic signed [PC_W-1:0] plane_next [NUM_PLANES][NUM_LANES];
    logic signed [PC_W-1:0] plane_reg  [NUM_PLANES][NUM_LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                row_reg[i] <= '0;
            end
            margin_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_ZERO:  row_reg[0] <= cfg_data;
                REG_ROW_ONE:   row_reg[1] <= cfg_data;
                REG_ROW_TWO:   row_reg[2] <= cfg_data;
                REG_ROW_THREE: row_reg[3] <= cfg_data;
                REG_MARGIN:    margin_reg <= cfg_data[MARGIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            row_ext[i] = LANES_W'(row_reg[i]);
            for (int j = 0; j < NUM_LANES; j++)
            begin
                r[i][j] = $signed(row_ext[i][j*COEF_WIDTH +: COEF_WIDTH]);
            end
        end
        for (int j = 0; j < NUM_LANES; j++)
        begin
            plane_next[0][j] = PC_W'(r[3][j]) + PC_W'(r[0][j]);
            plane_next[1][j] = PC_W'(r[3][j]) - PC_W'(r[0][j]);
            plane_next[2][j] = PC_W'(r[3][j]) + PC_W'(r[1][j]);
            plane_next[3][j] = PC_W'(r[3][j]) - PC_W'(r[1][j]);
            plane_next[4][j] = PC_W'(r[2][j]);
            plane_next[5][j] = PC_W'(r[3][j]) - PC_W'(r[2][j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int j = 0; j < NUM_LANES; j++)
                begin
                    plane_reg[p][j] <= '0;
                end
            end
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    assign plane_coef = plane_reg;
    assign margin     = margin_reg;

endmodule

`default_nettype wire

[rtl/aabbfc_pipe_ctrl.sv]
`default_nettype none

module aabbfc_pipe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output aabbfc_pkg::stage_en_t  stage_en
);
    import aabbfc_pkg::*;

    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic [3:0] ready;

    always_comb
    begin
        ready[3] = !valid_reg[3] || !out_stall;
        ready[2] = !valid_reg[2] || ready[3];
        ready[1] = !valid_reg[1] || ready[2];
        ready[0] = !valid_reg[0] || ready[1];

        valid_next[0] = ready[0] ? in_valid     : valid_reg[0];
        valid_next[1] = ready[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = ready[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = ready[3] ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall    = !ready[0];
    assign out_valid   = valid_reg[3];
    assign stage_en.s1 = ready[0];
    assign stage_en.s2 = ready[1];
    assign stage_en.s3 = ready[2];
    assign stage_en.s4 = ready[3];

endmodule

`default_nettype wire

[rtl/aabbfc_plane_eval.sv]
`default_nettype none

module aabbfc_plane_eval #(
    parameter int COEF_WIDTH = aabbfc_pkg::COEF_WIDTH_DEF,
    parameter int DV_W       = aabbfc_pkg::COORD_WIDTH_DEF + 1
) (
    input  wire logic                               clk,
    input  wire aabbfc_pkg::stage_en_t              stage_en,
    input  wire logic signed [COEF_WIDTH:0]         coef [aabbfc_pkg::NUM_LANES],
    input  wire logic signed [DV_W-1:0]             sum  [3],
    input  wire logic signed [DV_W-1:0]             dif  [3],
    input  wire logic [aabbfc_pkg::MARGIN_W-1:0]    margin,
    output logic                                    reject
);
    import aabbfc_pkg::*;

    localparam int AW = COEF_WIDTH + 2;
    localparam int PW = AW + DV_W;
    localparam int SW = PW + 3;

    logic signed [AW-1:0] abs_coef [3];
    logic signed [PW-1:0] pc_next [3];
    logic signed [PW-1:0] pe_next [3];
    logic signed [PW-1:0] pw_next;
    logic signed [PW-1:0] pc_reg [3];
    logic signed [PW-1:0] pe_reg [3];
    logic signed [PW-1:0] pw_reg;
    logic [MARGIN_W-1:0]  margin_reg;
    logic signed [SW-1:0] part_next [4];
    logic signed [SW-1:0] part_reg  [4];
    logic signed [SW-1:0] total;
    logic                 reject_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            abs_coef[j] = coef[j][COEF_WIDTH] ? -AW'(coef[j]) : AW'(coef[j]);
            pc_next[j]  = PW'(coef[j]) * PW'(sum[j]);
            pe_next[j]  = PW'(abs_coef[j]) * PW'(dif[j]);
        end
        pw_next = PW'(coef[3]) <<< (COORD_FRAC + 1);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.s2)
        begin
            pc_reg     <= pc_next;
            pe_reg     <= pe_next;
            pw_reg     <= pw_next;
            margin_reg <= margin;
        end
    end

    always_comb
    begin
        part_next[0] = SW'(pc_reg[0]) + SW'(pc_reg[1]);
        part_next[1] = SW'(pc_reg[2]) + SW'(pw_reg);
        part_next[2] = SW'(pe_reg[0]) + SW'(pe_reg[1]);
        part_next[3] = SW'(pe_reg[2]) + SW'($signed({1'b0, margin_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.s3)
        begin
            part_reg <= part_next;
        end
    end

    assign total = (part_reg[0] + part_reg[1]) + (part_reg[2] + part_reg[3]);

    always_ff @(posedge clk)
    begin
        if (stage_en.s4)
        begin
            reject_reg <= total[SW-1];
        end
    end

    assign reject = reject_reg;

endmodule

`default_nettype wire

[rtl/aabbfc_top_placeholder.sv]
`default_nettype none

module aabbfc_coord_prep #(
    parameter int COORD_WIDTH = aabbfc_pkg::COORD_WIDTH_DEF,
    parameter int DV_W        = aabbfc_pkg::COORD_WIDTH_DEF + 1
) (
    input  wire logic                               clk,
    input  wire logic                               load,
    input  wire logic [aabbfc_pkg::FIELD_W-1:0]     lo,
    input  wire logic [aabbfc_pkg::FIELD_W-1:0]     hi,
    output logic signed [DV_W-1:0]                  sum,
    output logic signed [DV_W-1:0]                  dif
);
    import aabbfc_pkg::*;

    localparam int CV_W = DV_W - 1;

    logic signed [CV_W-1:0] lo_val;
    logic signed [CV_W-1:0] hi_val;
    logic signed [DV_W-1:0] sum_reg;
    logic signed [DV_W-1:0] dif_reg;

    if (COORD_WIDTH > FIELD_W)
    begin : g_wide
        assign lo_val = $signed({1'b0, lo});
        assign hi_val = $signed({1'b0, hi});
    end
    else
    begin : g_narrow
        assign lo_val = $signed(lo[CV_W-1:0]);
        assign hi_val = $signed(hi[CV_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= DV_W'(hi_val) + DV_W'(lo_val);
            dif_reg <= DV_W'(hi_val) - DV_W'(lo_val);
        end
    end

    assign sum = sum_reg;
    assign dif = dif_reg;

endmodule

`default_nettype wire

[verif/aabb_frustum_cull_unit_test.sv]
`timescale 1ns / 1ps

module aabb_frustum_cull_unit_test;

    import aabbfc_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LANE_W       = COEF_WIDTH_DEF;
    localparam int BOXES_PER_SETTING = 40;

    localparam logic [ROW_W-1:0] CLIP_ROW_X = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] CLIP_ROW_Y = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] CLIP_ROW_Z = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] CLIP_ROW_W = 64'h1000_0000_0000_0000;
    localparam logic [ROW_W-1:0] LANES_MOST_NEGATIVE = 64'h8000_8000_8000_8000;
    localparam logic [ROW_W-1:0] LANES_MOST_POSITIVE = 64'h7FFF_7FFF_7FFF_7FFF;

    typedef struct packed {
        logic signed [FIELD_W-1:0] min_x;
        logic signed [FIELD_W-1:0] min_y;
        logic signed [FIELD_W-1:0] min_z;
        logic signed [FIELD_W-1:0] max_x;
        logic signed [FIELD_W-1:0] max_y;
        logic signed [FIELD_W-1:0] max_z;
    } box_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [FIELD_W-1:0] box_min_x = '0;
    logic signed [FIELD_W-1:0] box_min_y = '0;
    logic signed [FIELD_W-1:0] box_min_z = '0;
    logic signed [FIELD_W-1:0] box_max_x = '0;
    logic signed [FIELD_W-1:0] box_max_y = '0;
    logic signed [FIELD_W-1:0] box_max_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic box_visible;

    logic [ROW_W-1:0] matrix_rows [NUM_LANES];
    logic [MARGIN_W-1:0] margin_shadow;

    bit box_visible_expected [$];
    bit expected_visible;
    int send_gap_pct;
    int out_stall_pct;
    int failure_count;
    int boxes_sent;
    int visible_seen;
    int culled_seen;
    int setting_count;
    int cycle_count;

    aabb_frustum_cull_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .box_visible (box_visible)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // A box is culled when any of the six clip planes puts it wholly outside, less the margin.
    function automatic bit predict_visible(input box_t b);
        longint coef [NUM_LANES][NUM_LANES];
        longint plane [NUM_PLANES][NUM_LANES];
        longint mid [3];
        longint span [3];
        longint centre;
        longint extent;
        longint weight;
        logic signed [LANE_W-1:0] lane_value;
        bit visible;
        visible = 1'b1;
        for (int r = 0; r < NUM_LANES; r++)
            for (int j = 0; j < NUM_LANES; j++)
            begin
                lane_value = matrix_rows[r][j*LANE_W +: LANE_W];
                coef[r][j] = lane_value;
            end
        for (int j = 0; j < NUM_LANES; j++)
        begin
            plane[0][j] = coef[3][j] + coef[0][j];
            plane[1][j] = coef[3][j] - coef[0][j];
            plane[2][j] = coef[3][j] + coef[1][j];
            plane[3][j] = coef[3][j] - coef[1][j];
            plane[4][j] = coef[2][j];
            plane[5][j] = coef[3][j] - coef[2][j];
        end
        mid[0]  = longint'($signed(b.min_x)) + longint'($signed(b.max_x));
        mid[1]  = longint'($signed(b.min_y)) + longint'($signed(b.max_y));
        mid[2]  = longint'($signed(b.min_z)) + longint'($signed(b.max_z));
        span[0] = longint'($signed(b.max_x)) - longint'($signed(b.min_x));
        span[1] = longint'($signed(b.max_y)) - longint'($signed(b.min_y));
        span[2] = longint'($signed(b.max_z)) - longint'($signed(b.min_z));
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            centre = plane[p][3] * (longint'(2) << COORD_FRAC);
            extent = 0;
            for (int j = 0; j < 3; j++)
            begin
                weight = (plane[p][j] < 0) ? -plane[p][j] : plane[p][j];
                centre += plane[p][j] * mid[j];
                extent += weight * span[j];
            end
            if (centre + extent < -longint'(margin_shadow))
                visible = 1'b0;
        end
        return visible;
    endfunction

    function automatic box_t make_box(input int mnx, input int mny, input int mnz,
                                      input int mxx, input int mxy, input int mxz);
        box_t b;
        b.min_x = 16'(mnx);
        b.min_y = 16'(mny);
        b.min_z = 16'(mnz);
        b.max_x = 16'(mxx);
        b.max_y = 16'(mxy);
        b.max_z = 16'(mxz);
        return b;
    endfunction

    function automatic logic [15:0] extreme_word();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic box_t random_box();
        box_t b;
        int sel;
        int cx, cy, cz, hx, hy, hz;
        sel = $urandom_range(99);
        if (sel < 8)
            b = {$urandom, $urandom, $urandom};
        else if (sel < 12)
            b = {extreme_word(), extreme_word(), extreme_word(),
                 extreme_word(), extreme_word(), extreme_word()};
        else
        begin
            cx = $urandom_range(1536) - 768;
            cy = $urandom_range(1536) - 768;
            cz = $urandom_range(1536) - 768;
            hx = $urandom_range(384);
            hy = $urandom_range(384);
            hz = $urandom_range(384);
            if (sel < 20)
                b = make_box(cx + hx, cy + hy, cz - hz, cx - hx, cy - hy, cz + hz);
            else
                b = make_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
        end
        return b;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (box_visible_expected.size() == 0)
            begin
                failure_count++;
                if (failure_count <= 10)
                    $display("Unexpected output transaction: box_visible=%b", box_visible);
            end
            else
            begin
                expected_visible = box_visible_expected.pop_front();
                if (box_visible !== expected_visible)
                begin
                    failure_count++;
                    if (failure_count <= 10)
                        $display("Mismatch on box_visible: expected %b, got %b",
                                 expected_visible, box_visible);
                end
                if (expected_visible)
                    visible_seen++;
                else
                    culled_seen++;
            end
        end
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    task automatic send_box(input box_t b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        box_min_x <= b.min_x;
        box_min_y <= b.min_y;
        box_min_z <= b.min_z;
        box_max_x <= b.max_x;
        box_max_y <= b.max_y;
        box_max_z <= b.max_z;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        box_visible_expected = {box_visible_expected, predict_visible(b)};
        boxes_sent++;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (box_visible_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [ROW_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (index)
            REG_ROW_ZERO:  matrix_rows[0] = data;
            REG_ROW_ONE:   matrix_rows[1] = data;
            REG_ROW_TWO:   matrix_rows[2] = data;
            REG_ROW_THREE: matrix_rows[3] = data;
            REG_MARGIN:    margin_shadow = data[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [ROW_W-1:0] row0, input logic [ROW_W-1:0] row1,
                                input logic [ROW_W-1:0] row2, input logic [ROW_W-1:0] row3,
                                input logic [ROW_W-1:0] margin_word);
        drain_pipeline();
        write_register(REG_ROW_ZERO, row0);
        write_register(REG_ROW_ONE, row1);
        write_register(REG_ROW_TWO, row2);
        write_register(REG_ROW_THREE, row3);
        write_register(REG_MARGIN, margin_word);
        setting_count++;
    endtask

    task automatic load_random_setting(input int variant);
        logic [ROW_W-1:0] rows [NUM_LANES];
        logic [ROW_W-1:0] margin_word;
        int lane_value;
        margin_word = {$urandom, $urandom};
        case ($urandom_range(3))
            0: margin_word[MARGIN_W-1:0] = '0;
            1: margin_word[MARGIN_W-1:0] = '1;
            default: ;
        endcase
        for (int r = 0; r < NUM_LANES; r++)
        begin
            case (variant % 8)
                0: rows[r] = LANES_MOST_NEGATIVE;
                1: rows[r] = LANES_MOST_POSITIVE;
                2: rows[r] = {$urandom, $urandom};
                3: rows[r] = {extreme_word(), extreme_word(), extreme_word(), extreme_word()};
                default:
                begin
                    for (int j = 0; j < NUM_LANES; j++)
                    begin
                        if (r == j && r == 3)
                            lane_value = $urandom_range(8192, 2048);
                        else if (r == j)
                            lane_value = $urandom_range(8192, 1024);
                        else
                            lane_value = $urandom_range(1024) - 512;
                        if (r == j && $urandom_range(7) == 0)
                            lane_value = -lane_value;
                        rows[r][j*LANE_W +: LANE_W] = LANE_W'(lane_value);
                    end
                end
            endcase
        end
        load_setting(rows[0], rows[1], rows[2], rows[3], margin_word);
    endtask

    task automatic test_zero_matrix();
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
        send_box(random_box());
    endtask

    task automatic test_clip_cube();
        load_setting(CLIP_ROW_X, CLIP_ROW_Y, CLIP_ROW_Z, CLIP_ROW_W, '0);
        send_box(make_box(-128, -128, 64, 128, 128, 192));
        send_box(make_box(-600, -64, 64, -300, 64, 128));
        send_box(make_box(300, -64, 64, 600, 64, 128));
        send_box(make_box(-64, 300, 64, 64, 600, 128));
        send_box(make_box(-64, -64, -300, 64, 64, -1));
        send_box(make_box(-64, -64, 300, 64, 64, 600));
        send_box(make_box(-400, -64, 64, -256, 64, 128));
        send_box(make_box(200, 200, 200, -200, -200, 50));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    endtask

    task automatic test_reject_margin();
        load_setting(CLIP_ROW_X, CLIP_ROW_Y, CLIP_ROW_Z, CLIP_ROW_W,
                     {$urandom, 16'hFFFF, 16'd8191});
        send_box(make_box(-400, -64, 64, -257, 64, 128));
        load_setting(CLIP_ROW_X, CLIP_ROW_Y, CLIP_ROW_Z, CLIP_ROW_W, 64'd8192);
        send_box(make_box(-400, -64, 64, -257, 64, 128));
        load_setting(CLIP_ROW_X, CLIP_ROW_Y, CLIP_ROW_Z, CLIP_ROW_W, 64'd65535);
        send_box(make_box(-400, -64, 64, -257, 64, 128));
    endtask

    task automatic test_unused_index();
        load_setting(CLIP_ROW_X, CLIP_ROW_Y, CLIP_ROW_Z, CLIP_ROW_W, '0);
        send_box(make_box(-600, -64, 64, -300, 64, 128));
        drain_pipeline();
        for (int idx = REG_MARGIN + 1; idx < 2 ** CFG_INDEX_W; idx++)
            write_register(CFG_INDEX_W'(idx), {$urandom, $urandom});
        send_box(make_box(-600, -64, 64, -300, 64, 128));
        send_box(make_box(-128, -128, 64, 128, 128, 192));
    endtask

    task automatic test_extreme_matrix();
        load_setting(LANES_MOST_NEGATIVE, LANES_MOST_NEGATIVE, LANES_MOST_NEGATIVE,
                     LANES_MOST_NEGATIVE, '0);
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
        load_setting(LANES_MOST_POSITIVE, LANES_MOST_POSITIVE, LANES_MOST_POSITIVE,
                     LANES_MOST_POSITIVE, 64'hFFFF);
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    endtask

    task automatic test_random_boxes(input int gap_pct, input int stall_pct, input int total);
        send_gap_pct  = gap_pct;
        out_stall_pct = stall_pct;
        for (int n = 0; n < total; n++)
        begin
            if (n % BOXES_PER_SETTING == 0)
                load_random_setting(n / BOXES_PER_SETTING);
            send_box(random_box());
        end
    endtask

    initial
    begin
        for (int r = 0; r < NUM_LANES; r++)
            matrix_rows[r] = '0;
        margin_shadow = '0;
        send_gap_pct  = 29;
        out_stall_pct = 72;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_matrix();
        test_clip_cube();
        test_reject_margin();
        test_unused_index();
        test_extreme_matrix();
        test_random_boxes(29, 72, 333);
        test_random_boxes(72, 29, 333);
        test_random_boxes(0, 0, 334);
        drain_pipeline();

        $display("Sent %0d boxes through %0d matrix and margin settings.",
                 boxes_sent, setting_count);
        $display("Results checked: %0d visible, %0d culled, %0d failures.",
                 visible_seen, culled_seen, failure_count);
        if (failure_count == 0 && box_visible_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
